### rtl/ppid_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package ppid_pkg;

    // Widths of the fixed fields on the ports
    localparam int FIELD_W    = 32;
    localparam int LIMIT_W    = 31;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_PROP_GAIN   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INTEG_GAIN  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DERIV_GAIN  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DEAD_BAND   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_INTEG_LIMIT = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_STEP_LIMIT  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_OUT_LIMIT   = 3'd6;

    // Input beat: target and feedback
    typedef struct packed {
        logic signed [FIELD_W-1:0] set_point;
        logic signed [FIELD_W-1:0] measured;
    } t_in_beat;

    // Output beat: new drive and dead band flag
    typedef struct packed {
        logic signed [FIELD_W-1:0] drive;
        logic                      in_dead_band;
    } t_out_beat;

    // Step sequencer states
    typedef enum logic [3:0] {
        S_IDLE,
        S_ERR,
        S_BAND,
        S_PSTART,
        S_PWAIT,
        S_SUM1,
        S_SUM2,
        S_ISTART,
        S_IWAIT,
        S_DIFF,
        S_DSTART,
        S_DWAIT,
        S_STEP,
        S_CLAMP,
        S_DONE
    } t_state;

endpackage

`default_nettype wire

### rtl/ppid_mul.sv
`timescale 1ns / 1ps
`default_nettype none

// Shared fixed point multiplier: coefficient times operand, floored by
// FRAC_BITS and saturated. The operand is split into two halves that go
// through one narrow multiplier in consecutive cycles.
module ppid_mul #(
    parameter int DATA_WIDTH = 32,
    parameter int FRAC_BITS  = 16
) (
    input  wire logic                                     i_clk,
    input  wire logic                                     i_rst_n,
    input  wire logic                                     i_start,
    input  wire logic signed [ppid_pkg::FIELD_W-1:0]      i_coef,
    input  wire logic signed [DATA_WIDTH-1:0]             i_opnd,
    output logic                                          o_done,
    output logic signed [DATA_WIDTH-1:0]                  o_result
);

    localparam int LO  = (DATA_WIDTH + 1) / 2;
    localparam int PW  = ppid_pkg::FIELD_W + DATA_WIDTH;
    localparam int PPW = ppid_pkg::FIELD_W + LO + 1;

    localparam logic signed [DATA_WIDTH-1:0] SMAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};
    localparam logic signed [DATA_WIDTH-1:0] SMIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};

    logic signed [ppid_pkg::FIELD_W-1:0] r_coef;
    logic signed [DATA_WIDTH-1:0]        r_opnd;
    logic [3:0]                          r_stage;
    logic signed [PPW-1:0]               r_pp;
    logic signed [PW-1:0]                r_acc;
    logic                                r_done;
    logic signed [DATA_WIDTH-1:0]        r_result;

    logic signed [LO:0]       w_lo_b;
    logic signed [LO:0]       w_hi_b;
    logic signed [LO:0]       w_mul_b;
    logic signed [PPW-1:0]    w_pp;
    logic signed [PW-1:0]     w_q;
    logic                     w_ovf;
    logic signed [DATA_WIDTH-1:0] w_sat;

    // Pick the operand half and multiply
    assign w_lo_b  = $signed({1'b0, r_opnd[LO-1:0]});
    assign w_hi_b  = (LO+1)'($signed(r_opnd[DATA_WIDTH-1:LO]));
    assign w_mul_b = r_stage[0] ? w_lo_b : w_hi_b;
    assign w_pp    = r_coef * w_mul_b;

    // Floor the fraction and saturate to the data range
    assign w_q   = r_acc >>> FRAC_BITS;
    assign w_ovf = (w_q[PW-1:DATA_WIDTH-1] != {(PW-DATA_WIDTH+1){w_q[DATA_WIDTH-1]}});
    assign w_sat = w_ovf ? (w_q[PW-1] ? SMIN : SMAX) : w_q[DATA_WIDTH-1:0];

    // Advance the stage marks
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stage <= '0;
            r_done  <= 1'b0;
        end else begin
            r_stage <= {r_stage[2:0], i_start};
            r_done  <= r_stage[3];
        end
    end

    // Latch operands, form partial products, accumulate, floor and saturate
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_coef <= i_coef;
            r_opnd <= i_opnd;
        end
        if (r_stage[0]) begin
            r_pp <= w_pp;
        end
        if (r_stage[1]) begin
            r_acc <= PW'(r_pp);
            r_pp  <= w_pp;
        end
        if (r_stage[2]) begin
            r_acc <= r_acc + (PW'(r_pp) <<< LO);
        end
        if (r_stage[3]) begin
            r_result <= w_sat;
        end
    end

    assign o_done   = r_done;
    assign o_result = r_result;

endmodule

`default_nettype wire

### rtl/positional_pid_step_top.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Handshake                  Beat
// in        input      i_in_valid / o_in_stall    ppid_pkg::t_in_beat
// out       output     o_out_valid / i_out_stall  ppid_pkg::t_out_beat
// cfg       input      i_cfg_we (write only)      i_cfg_idx, i_cfg_data
//
// An item whose error lies outside the dead band makes three passes through the
// shared multiplier before the next accept; one inside the dead band makes none.
// A new item is accepted only once the last result has entered the output register.
// Reset is synchronous, active low, and clears gains, limits and history.
// A result waits in the output register while the out channel stalls; the
// sequencer holds in its last state until the register frees.
module positional_pid_step_top #(
    parameter int DATA_WIDTH = 32,
    parameter int FRAC_BITS  = 16
) (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire logic                                  i_in_valid,
    output logic                                       o_in_stall,
    input  wire ppid_pkg::t_in_beat                    i_in_beat,
    output logic                                       o_out_valid,
    input  wire logic                                  i_out_stall,
    output ppid_pkg::t_out_beat                        o_out_beat,
    input  wire logic                                  i_cfg_we,
    input  wire logic [ppid_pkg::CFG_IDX_W-1:0]        i_cfg_idx,
    input  wire logic [ppid_pkg::CFG_DATA_W-1:0]       i_cfg_data
);

    localparam int DW = DATA_WIDTH;
    localparam int WW = ((DATA_WIDTH > ppid_pkg::FIELD_W) ? DATA_WIDTH
                                                           : ppid_pkg::FIELD_W) + 2;
    localparam int FW = ppid_pkg::FIELD_W;
    localparam int LW = ppid_pkg::LIMIT_W;

    localparam logic signed [DW-1:0] SMAX = {1'b0, {(DW-1){1'b1}}};
    localparam logic signed [DW-1:0] SMIN = {1'b1, {(DW-1){1'b0}}};

    // Saturate a working value to the data range
    function automatic logic signed [DW-1:0] f_sat(input logic signed [WW-1:0] v);
        logic                   ovf;
        logic signed [DW-1:0]   res;
        ovf = (v[WW-1:DW-1] != {(WW-DW+1){v[DW-1]}});
        if (ovf) begin
            res = v[WW-1] ? SMIN : SMAX;
        end else begin
            res = v[DW-1:0];
        end
        return res;
    endfunction

    function automatic logic signed [WW-1:0] f_ext(input logic signed [DW-1:0] v);
        return WW'(v);
    endfunction

    function automatic logic signed [WW-1:0] f_lim(input logic [LW-1:0] v);
        return WW'({1'b0, v});
    endfunction

    function automatic logic signed [WW-1:0] f_abs(input logic signed [WW-1:0] v);
        return v[WW-1] ? -v : v;
    endfunction

    ppid_pkg::t_state r_state;
    ppid_pkg::t_state n_state;

    // Configuration
    logic signed [FW-1:0] r_prop_gain;
    logic signed [FW-1:0] r_integ_gain;
    logic signed [FW-1:0] r_deriv_gain;
    logic [LW-1:0]        r_dead_band;
    logic [LW-1:0]        r_integ_limit;
    logic [LW-1:0]        r_step_limit;
    logic [LW-1:0]        r_out_limit;

    // History
    logic signed [DW-1:0] r_prev_out;
    logic signed [DW-1:0] r_prev_err;
    logic signed [DW-1:0] r_sum;

    // Working registers
    logic signed [FW-1:0] r_sp;
    logic signed [FW-1:0] r_meas;
    logic signed [DW-1:0] r_err;
    logic signed [DW-1:0] r_p;
    logic signed [DW-1:0] r_tmp;
    logic signed [DW-1:0] r_o;
    logic signed [DW-1:0] r_res_drive;
    logic                 r_res_band;

    // Output register
    logic                 r_out_valid;
    ppid_pkg::t_out_beat  r_out_beat;

    logic                 w_in_acc;
    logic                 w_out_load;
    logic                 w_mul_start;
    logic signed [FW-1:0] w_mul_coef;
    logic signed [DW-1:0] w_mul_opnd;
    logic                 w_mul_done;
    logic signed [DW-1:0] w_mul_res;

    logic signed [WW-1:0] w_diff;
    logic                 w_in_band;
    logic signed [WW-1:0] w_sum_add;
    logic signed [WW-1:0] w_sum_clamp;
    logic signed [WW-1:0] w_delta;
    logic signed [WW-1:0] w_stepped;
    logic signed [WW-1:0] w_clamped;

    assign w_in_acc   = i_in_valid && (r_state == ppid_pkg::S_IDLE);
    assign w_out_load = (r_state == ppid_pkg::S_DONE) && (!r_out_valid || !i_out_stall);

    // Shared multiplier
    ppid_mul #(
        .DATA_WIDTH (DATA_WIDTH),
        .FRAC_BITS  (FRAC_BITS)
    ) u_mul (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (w_mul_start),
        .i_coef   (w_mul_coef),
        .i_opnd   (w_mul_opnd),
        .o_done   (w_mul_done),
        .o_result (w_mul_res)
    );

    // Hold the sequencer state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ppid_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and multiplier requests
    always_comb begin
        n_state     = r_state;
        o_in_stall  = (r_state != ppid_pkg::S_IDLE);
        w_mul_start = 1'b0;
        w_mul_coef  = r_prop_gain;
        w_mul_opnd  = r_err;
        unique case (r_state)
            ppid_pkg::S_IDLE: begin
                if (w_in_acc) begin
                    n_state = ppid_pkg::S_ERR;
                end
            end
            ppid_pkg::S_ERR:    n_state = ppid_pkg::S_BAND;
            ppid_pkg::S_BAND: begin
                n_state = w_in_band ? ppid_pkg::S_DONE : ppid_pkg::S_PSTART;
            end
            ppid_pkg::S_PSTART: begin
                w_mul_start = 1'b1;
                n_state     = ppid_pkg::S_PWAIT;
            end
            ppid_pkg::S_PWAIT: begin
                if (w_mul_done) begin
                    n_state = ppid_pkg::S_SUM1;
                end
            end
            ppid_pkg::S_SUM1:   n_state = ppid_pkg::S_SUM2;
            ppid_pkg::S_SUM2:   n_state = ppid_pkg::S_ISTART;
            ppid_pkg::S_ISTART: begin
                w_mul_start = 1'b1;
                w_mul_coef  = r_integ_gain;
                w_mul_opnd  = r_sum;
                n_state     = ppid_pkg::S_IWAIT;
            end
            ppid_pkg::S_IWAIT: begin
                if (w_mul_done) begin
                    n_state = ppid_pkg::S_DIFF;
                end
            end
            ppid_pkg::S_DIFF:   n_state = ppid_pkg::S_DSTART;
            ppid_pkg::S_DSTART: begin
                w_mul_start = 1'b1;
                w_mul_coef  = r_deriv_gain;
                w_mul_opnd  = r_tmp;
                n_state     = ppid_pkg::S_DWAIT;
            end
            ppid_pkg::S_DWAIT: begin
                if (w_mul_done) begin
                    n_state = ppid_pkg::S_STEP;
                end
            end
            ppid_pkg::S_STEP:   n_state = ppid_pkg::S_CLAMP;
            ppid_pkg::S_CLAMP:  n_state = ppid_pkg::S_DONE;
            ppid_pkg::S_DONE: begin
                if (w_out_load) begin
                    n_state = ppid_pkg::S_IDLE;
                end
            end
            default:            n_state = ppid_pkg::S_IDLE;
        endcase
    end

    // Arithmetic for each step
    always_comb begin
        w_diff    = f_ext(f_sat(WW'(r_sp) - WW'(r_meas)));
        w_in_band = f_abs(f_ext(r_err)) < f_lim(r_dead_band);

        w_sum_add = f_ext(r_sum) + f_ext(r_err);

        w_sum_clamp = f_ext(r_sum);
        if (w_sum_clamp > f_lim(r_integ_limit)) begin
            w_sum_clamp = f_lim(r_integ_limit);
        end
        if (w_sum_clamp < -f_lim(r_integ_limit)) begin
            w_sum_clamp = -f_lim(r_integ_limit);
        end

        w_delta = f_ext(r_o) - f_ext(r_prev_out);
        priority if (w_delta > f_lim(r_step_limit)) begin
            w_stepped = f_ext(r_prev_out) + f_lim(r_step_limit);
        end else if (w_delta < -f_lim(r_step_limit)) begin
            w_stepped = f_ext(r_prev_out) - f_lim(r_step_limit);
        end else begin
            w_stepped = f_ext(r_o);
        end

        w_clamped = f_ext(r_o);
        if (w_clamped > f_lim(r_out_limit)) begin
            w_clamped = f_lim(r_out_limit);
        end
        if (w_clamped < -f_lim(r_out_limit)) begin
            w_clamped = -f_lim(r_out_limit);
        end
    end

    // Write configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prop_gain   <= '0;
            r_integ_gain  <= '0;
            r_deriv_gain  <= '0;
            r_dead_band   <= '0;
            r_integ_limit <= '0;
            r_step_limit  <= '0;
            r_out_limit   <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                ppid_pkg::CFG_PROP_GAIN:   r_prop_gain   <= i_cfg_data;
                ppid_pkg::CFG_INTEG_GAIN:  r_integ_gain  <= i_cfg_data;
                ppid_pkg::CFG_DERIV_GAIN:  r_deriv_gain  <= i_cfg_data;
                ppid_pkg::CFG_DEAD_BAND:   r_dead_band   <= i_cfg_data[LW-1:0];
                ppid_pkg::CFG_INTEG_LIMIT: r_integ_limit <= i_cfg_data[LW-1:0];
                ppid_pkg::CFG_STEP_LIMIT:  r_step_limit  <= i_cfg_data[LW-1:0];
                ppid_pkg::CFG_OUT_LIMIT:   r_out_limit   <= i_cfg_data[LW-1:0];
                default: ;
            endcase
        end
    end

    // Update the controller history
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_out <= '0;
            r_prev_err <= '0;
            r_sum      <= '0;
        end else begin
            unique case (r_state)
                ppid_pkg::S_BAND: begin
                    if (w_in_band) begin
                        r_prev_out <= '0;
                        r_prev_err <= '0;
                    end
                end
                ppid_pkg::S_SUM1: begin
                    if (f_abs(f_ext(r_p)) < f_lim(r_out_limit)) begin
                        r_sum <= f_sat(w_sum_add);
                    end
                end
                ppid_pkg::S_SUM2:  r_sum <= f_sat(w_sum_clamp);
                ppid_pkg::S_CLAMP: begin
                    r_prev_err <= r_err;
                    r_prev_out <= f_sat(w_clamped);
                end
                default: ;
            endcase
        end
    end

    // Capture the input beat and step the working values
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_sp   <= i_in_beat.set_point;
            r_meas <= i_in_beat.measured;
        end
        unique case (r_state)
            ppid_pkg::S_ERR:  r_err <= w_diff[DW-1:0];
            ppid_pkg::S_BAND: begin
                r_res_drive <= '0;
                r_res_band  <= w_in_band;
            end
            ppid_pkg::S_PWAIT: begin
                if (w_mul_done) begin
                    r_p <= w_mul_res;
                end
            end
            ppid_pkg::S_IWAIT: begin
                if (w_mul_done) begin
                    r_o <= f_sat(f_ext(r_p) + f_ext(w_mul_res));
                end
            end
            ppid_pkg::S_DIFF:  r_tmp <= f_sat(f_ext(r_err) - f_ext(r_prev_err));
            ppid_pkg::S_DWAIT: begin
                if (w_mul_done) begin
                    r_o <= f_sat(f_ext(r_o) + f_ext(w_mul_res));
                end
            end
            ppid_pkg::S_STEP:  r_o <= f_sat(w_stepped);
            ppid_pkg::S_CLAMP: r_res_drive <= f_sat(w_clamped);
            default: ;
        endcase
    end

    // Load or drain the output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_out_beat.drive        <= FW'(r_res_drive);
            r_out_beat.in_dead_band <= r_res_band;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_beat  = r_out_beat;

`ifndef SYNTHESIS
    a_mul_done_waiting: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_mul_done |-> (r_state == ppid_pkg::S_PWAIT || r_state == ppid_pkg::S_IWAIT ||
                        r_state == ppid_pkg::S_DWAIT))
        else $error("multiplier finished outside a wait state");

    a_band_zero_drive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_beat.in_dead_band) |-> (o_out_beat.drive == '0))
        else $error("dead band beat carries a nonzero drive");

    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> (r_state == ppid_pkg::S_ERR))
        else $error("accepted beat did not start a step");

    a_load_sets_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_out_load |=> (o_out_valid && r_state == ppid_pkg::S_IDLE))
        else $error("finished step did not present a result");
`endif

endmodule

`default_nettype wire
